### rtl/cbd_pkg.sv
// Shared types and constants for the circular byte deque.
`default_nettype none
package cbd_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  localparam int unsigned OUT_USER_BITS = 4;

  typedef struct packed {
    logic fire;
    act_e act;
  } cbd_ctrl_t;

endpackage
`default_nettype wire

### rtl/cbd_cell.sv
// One slot of the deque chain: holds one item and trades it with its neighbors.
`default_nettype none
module cbd_cell
  import cbd_pkg::*;
#(
  parameter int unsigned ITEM_BITS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cbd_ctrl_t            ctrl_i,
  input  wire logic [ITEM_BITS-1:0] item_i,
  input  wire logic                 left_valid_i,
  input  wire logic [ITEM_BITS-1:0] left_data_i,
  input  wire logic                 right_valid_i,
  input  wire logic [ITEM_BITS-1:0] right_data_i,
  output logic                      valid_o,
  output logic [ITEM_BITS-1:0]      data_o,
  output logic                      valid_next_o,
  output logic [ITEM_BITS-1:0]      rear_data_o
);

  logic                 valid_q, valid_d;
  logic [ITEM_BITS-1:0] data_q, data_d;
  logic                 is_rear;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.fire) begin
      case (ctrl_i.act)
        ACT_PUSH_FRONT: begin
          valid_d = left_valid_i;
          data_d  = left_data_i;
        end
        ACT_PUSH_REAR: begin
          if (!valid_q && left_valid_i) begin
            valid_d = 1'b1;
            data_d  = item_i;
          end
        end
        ACT_POP_FRONT: begin
          valid_d = right_valid_i;
          data_d  = right_data_i;
        end
        ACT_POP_REAR: begin
          if (valid_q && !right_valid_i) begin
            valid_d = 1'b0;
          end
        end
        default: begin
          valid_d = valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign is_rear      = valid_q && !right_valid_i;
  assign valid_o      = valid_q;
  assign data_o       = data_q;
  assign valid_next_o = valid_d;
  assign rear_data_o  = is_rear ? data_q : '0;

endmodule
`default_nettype wire

### rtl/circular_byte_deque.sv
// Top level of the circular byte deque: a chain of item cells with a registered result.
//
// Channel | Dir | tdata                    | tuser
// s_axis  | in  | item [ITEM_BITS-1:0]     | action [1:0]
// m_axis  | out | popped_item [ITEM_BITS-1:0] | status [1:0], is_empty [2], is_full [3]
//
// One item per cycle while the output is not stalled: the cell chain shifts or fills in
// the accept cycle and the result lands in the output register on the same edge.
// A new item is taken while the output register is free or being drained.
// Reset clears every cell's valid flag, so the deque starts empty; holds DEPTH-1 items.
// A stalled output holds its result and blocks further input.
`default_nettype none
module circular_byte_deque
  import cbd_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned ITEM_BITS = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // item (ITEM_BITS), zero padding above
  input  wire logic [((ITEM_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // action [1:0]
  input  wire logic [1:0]                          s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // popped_item (ITEM_BITS), zero padding above
  output logic [((ITEM_BITS+7)/8)*8-1:0]           m_axis_tdata,
  // status [1:0], is_empty [2], is_full [3]
  output logic [OUT_USER_BITS-1:0]                 m_axis_tuser
);

  localparam int unsigned CELLS     = DEPTH - 1;
  localparam int unsigned DATA_BITS = ((ITEM_BITS + 7) / 8) * 8;

  logic                 v_ext [CELLS+2];
  logic [ITEM_BITS-1:0] d_ext [CELLS+2];
  logic                 v_next [CELLS];
  logic [ITEM_BITS-1:0] rear_part [CELLS];

  logic                 accept;
  act_e                 act;
  logic [ITEM_BITS-1:0] item;
  logic                 is_push;
  logic                 full_now, empty_now;
  logic                 reject;
  cbd_ctrl_t            ctrl;
  logic [ITEM_BITS-1:0] rear_item;
  logic [ITEM_BITS-1:0] popped_d;
  status_e              status_d;

  logic                 out_valid_q;
  logic [ITEM_BITS-1:0] popped_q;
  status_e              status_q;
  logic                 empty_q, full_q;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign act    = act_e'(s_axis_tuser);
  assign item   = s_axis_tdata[ITEM_BITS-1:0];
  assign is_push = (act == ACT_PUSH_FRONT) || (act == ACT_PUSH_REAR);

  assign full_now  = v_ext[CELLS];
  assign empty_now = !v_ext[1];
  assign reject    = is_push ? full_now : empty_now;

  assign ctrl.fire = accept && !reject;
  assign ctrl.act  = act;

  assign v_ext[0]       = 1'b1;
  assign d_ext[0]       = item;
  assign v_ext[CELLS+1] = 1'b0;
  assign d_ext[CELLS+1] = '0;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    cbd_cell #(
      .ITEM_BITS(ITEM_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .item_i       (item),
      .left_valid_i (v_ext[k]),
      .left_data_i  (d_ext[k]),
      .right_valid_i(v_ext[k+2]),
      .right_data_i (d_ext[k+2]),
      .valid_o      (v_ext[k+1]),
      .data_o       (d_ext[k+1]),
      .valid_next_o (v_next[k]),
      .rear_data_o  (rear_part[k])
    );
  end

  always_comb begin
    rear_item = '0;
    for (int unsigned k = 0; k < CELLS; k++) begin
      rear_item = rear_item | rear_part[k];
    end
  end

  always_comb begin
    popped_d = '0;
    status_d = ST_DONE;
    if (reject) begin
      status_d = is_push ? ST_OVERFLOW : ST_UNDERFLOW;
    end else begin
      case (act)
        ACT_POP_FRONT: popped_d = d_ext[1];
        ACT_POP_REAR:  popped_d = rear_item;
        default:       popped_d = '0;
      endcase
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
      empty_q  <= !v_next[0];
      full_q   <= v_next[CELLS-1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DATA_BITS'(popped_q);
  assign m_axis_tuser  = {full_q, empty_q, status_q};

  logic chain_gap;
  always_comb begin
    chain_gap = 1'b0;
    for (int unsigned k = 1; k < CELLS; k++) begin
      chain_gap = chain_gap | (v_ext[k+1] && !v_ext[k]);
    end
  end

  a_chain_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !chain_gap)
    else $error("deque cells hold a gap");

  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_push && full_now) |=> (m_axis_tuser[1:0] == ST_OVERFLOW))
    else $error("push into full deque not flagged");

  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_push && empty_now) |=>
      (m_axis_tuser[1:0] == ST_UNDERFLOW && m_axis_tdata == '0))
    else $error("pop from empty deque not flagged");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[2] && m_axis_tuser[3]))
    else $error("deque reported both empty and full");

endmodule
`default_nettype wire
